### rtl/pctw_pkg.sv
// Package for the PLL channel table word calculator.
// Holds shared constants, the item record passed from front to back, and the
// sequencer state type. No dependencies.
package pctw_pkg;

    localparam logic [31:0] TBL_MAGIC     = 32'h1234_5675;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          IDX_W         = 8;
    localparam int          XO_W          = 15;
    localparam int          LO_W          = 13;
    localparam logic [7:0]  IDX_OFFSET    = 8'd1;
    localparam logic [7:0]  IDX_FREQ_BASE = 8'd114;
    localparam logic [7:0]  IDX_END       = 8'd199;
    localparam logic [12:0] LO_CH_BASE    = 13'd4824;
    localparam logic [12:0] LO_CH_LAST    = 13'd4968;
    localparam logic [12:0] LO_FREQ_ZERO  = 13'd3840;
    localparam logic [12:0] LO_FREQ_BASE  = 13'd4802;
    localparam logic [3:0]  CH_LAST       = 4'd13;
    localparam logic [31:0] M_DEN         = 32'd1280000000;
    localparam logic [26:0] D_NOM         = 27'd64000000;
    localparam logic [14:0] XO_NEG_LIMIT  = 15'd16384;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    // Word codes within one channel
    localparam logic [2:0] K_W0     = 3'd0;
    localparam logic [2:0] K_W1     = 3'd1;
    localparam logic [2:0] K_RX_N1  = 3'd2;
    localparam logic [2:0] K_RX_INV = 3'd3;
    localparam logic [2:0] K_RX_DEC = 3'd4;
    localparam logic [2:0] K_TX_N1  = 3'd5;
    localparam logic [2:0] K_TX_INV = 3'd6;
    localparam logic [2:0] K_TX_DEC = 3'd7;

    typedef enum logic [0:0] {
        KIND_IMM,
        KIND_PLL
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [31:0]       imm;
        logic [LO_W-1:0]   lo;
        logic              chan;
        logic [2:0]        k;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_N2,
        S_DIV_F,
        S_MUL,
        S_DIV_T,
        S_DIV_N1,
        S_DIV_X,
        S_EMIT
    } state_t;

endpackage

### rtl/pctw_front.sv
// Front end: accepts word requests and classifies them into items.
// Depends on pctw_pkg.
module pctw_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pctw_pkg::IDX_W-1:0]   word_index,
    input  logic [pctw_pkg::XO_W-1:0]    xo_offset_code,
    input  logic                         queue_full,
    output logic                         push,
    output pctw_pkg::item_t              item
);
    import pctw_pkg::*;

    logic [7:0] rel;
    logic [3:0] ch;
    logic [7:0] fk;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        rel       = word_index - 8'd2;
        ch        = rel[6:3];
        fk        = word_index - IDX_FREQ_BASE;
        item.kind = KIND_IMM;
        item.imm  = '0;
        item.lo   = '0;
        item.chan = 1'b0;
        item.k    = K_W0;
        if (word_index == '0) begin
            item.imm = TBL_MAGIC;
        end else if (word_index == IDX_OFFSET) begin
            item.imm = {17'd0, xo_offset_code};
        end else if (word_index < IDX_FREQ_BASE) begin
            item.kind = KIND_PLL;
            item.chan = 1'b1;
            item.k    = rel[2:0];
            item.lo   = (ch == CH_LAST) ? LO_CH_LAST
                                        : LO_CH_BASE + LO_W'(ch) * LO_W'(10);
        end else if (word_index < IDX_END) begin
            item.kind = KIND_PLL;
            item.lo   = (fk == '0) ? LO_FREQ_ZERO
                                   : LO_FREQ_BASE + {4'd0, fk, 1'b0} - LO_W'(2);
        end
    end
endmodule

### rtl/pctw_queue.sv
// Short queue of classified items between front and back.
// Depends on pctw_pkg.
module pctw_queue #(
    parameter int DEPTH = pctw_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pctw_pkg::item_t push_item,
    input  logic            pop,
    output pctw_pkg::item_t pop_item,
    output logic            full,
    output logic            empty
);
    import pctw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end
endmodule

### rtl/pctw_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on nothing beyond its ports.
module pctw_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quot,
    output logic [31:0] rem
);
    logic        busy_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quot_reg;
    logic [31:0] rem_reg, den_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    always_comb begin
        shifted = {rem_reg, quot_reg[63]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            // Keep the remainder when it falls short of the divisor
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
            end else begin
                rem_reg <= shifted[31:0];
            end
            quot_reg <= {quot_reg[62:0], !diff[32]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

### rtl/pctw_back.sv
// Back end: sequences the table arithmetic over the shared divider and
// holds the result register. Depends on pctw_pkg and pctw_div.
module pctw_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pctw_pkg::XO_W-1:0] xo_offset_code,
    input  logic                      queue_empty,
    input  pctw_pkg::item_t           queue_item,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               table_word
);
    import pctw_pkg::*;

    // floor(x / 78125) = (x * RECIP_M) >> 61 for x below 2^44; 1.28e9 = 78125 << 14
    localparam logic [44:0] RECIP_M     = 45'd29514790517936;
    localparam logic [2:0]  T_STEPS     = 3'd4;
    // floor(y / 15) = (y * TX_RECIP) >> 35 for y below 2^32
    localparam logic [31:0] TX_RECIP    = 32'h8888_8889;
    localparam logic [31:0] TX_DEC_STEP = 32'd143165576;

    state_t      state_reg, state_next;
    logic        launched_reg, launched_next;
    logic [2:0]  step_reg, step_next;
    item_t       item_reg;
    logic [29:0] b_reg;
    logic [36:0] a_reg;
    logic [8:0]  n2_reg;
    logic [31:0] r_reg;
    logic [19:0] f_reg;
    logic [57:0] num_reg;
    logic [89:0] acc_reg;
    logic [27:0] q_reg;
    logic [31:0] n1_reg;
    logic [31:0] word_reg, word_next;
    logic        res_valid_reg;
    logic [31:0] res_reg;

    logic        div_start, div_done;
    logic [63:0] div_num, div_quot;
    logic [31:0] div_den, div_rem;
    logic [26:0] d_val;
    logic [27:0] p_val;
    logic        load_res;
    logic [21:0] mx_a;
    logic [22:0] mx_b;
    logic [44:0] mx_prod;
    logic [89:0] mx_term;
    logic [27:0] q_calc;
    logic [63:0] tx_prod;
    logic [31:0] tx_n1;
    logic [3:0]  tx_r, tx_rp1;
    logic [31:0] tx_dec;
    logic        n1_done;
    logic [31:0] n1_val;

    pctw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign m_tvalid   = res_valid_reg;
    assign table_word = res_reg;

    always_comb begin
        // Signed offset: codes above the limit wrap to negative
        if (xo_offset_code > XO_NEG_LIMIT) begin
            d_val = D_NOM - 27'd32768 + {12'd0, xo_offset_code};
        end else begin
            d_val = D_NOM + {12'd0, xo_offset_code};
        end
        p_val = {n2_reg, 19'd0} + {8'd0, f_reg};
    end

    // Reciprocal scaling by 1.28e9, one partial product per step
    always_comb begin
        case (step_reg[1:0])
            2'd0: begin
                mx_a = num_reg[35:14];
                mx_b = RECIP_M[22:0];
            end
            2'd1: begin
                mx_a = num_reg[35:14];
                mx_b = {1'b0, RECIP_M[44:23]};
            end
            2'd2: begin
                mx_a = num_reg[57:36];
                mx_b = RECIP_M[22:0];
            end
            default: begin
                mx_a = num_reg[57:36];
                mx_b = {1'b0, RECIP_M[44:23]};
            end
        endcase
        mx_prod = {23'd0, mx_a} * {22'd0, mx_b};
        case (step_reg[1:0])
            2'd0:    mx_term = {45'd0, mx_prod};
            2'd1:    mx_term = {22'd0, mx_prod, 23'd0};
            2'd2:    mx_term = {23'd0, mx_prod, 22'd0};
            default: mx_term = {mx_prod, 45'd0};
        endcase
        q_calc = acc_reg[88:61];
    end

    // Transmit words: divide 2Q by 15 and take the rounded remainder share
    always_comb begin
        tx_prod = {35'd0, q_reg, 1'b0} * {32'd0, TX_RECIP};
        tx_n1   = {3'd0, tx_prod[63:35]};
        tx_r    = {q_reg[2:0], 1'b0} + n1_reg[3:0];
        tx_rp1  = tx_r + 4'd1;
        tx_dec  = ({28'd0, tx_r} * TX_DEC_STEP) + {29'd0, tx_rp1[3:1]};
        n1_val  = (item_reg.k < K_TX_N1) ? div_quot[31:0] : tx_n1;
    end

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        step_next     = step_reg;
        word_next     = word_reg;
        pop           = 1'b0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        load_res      = 1'b0;
        n1_done       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!queue_empty) begin
                    pop = 1'b1;
                    if (queue_item.kind == KIND_IMM) begin
                        word_next  = queue_item.imm;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_DIV_N2;
                    end
                end
            end
            S_DIV_N2: begin
                div_num = {27'd0, a_reg};
                div_den = {2'd0, b_reg};
                if (!launched_reg) begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end else if (div_done) begin
                    launched_next = 1'b0;
                    state_next    = S_DIV_F;
                end
            end
            S_DIV_F: begin
                div_num = {14'd0, r_reg[29:0], 20'd0} + {34'd0, b_reg};
                div_den = {1'b0, b_reg, 1'b0};
                if (!launched_reg) begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end else if (div_done) begin
                    launched_next = 1'b0;
                    // Fraction field wraps; n2 is not bumped
                    word_next = {item_reg.chan, 3'd0, n2_reg, div_quot[18:0]};
                    if (!item_reg.chan || item_reg.k == K_W0) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                step_next  = '0;
                state_next = S_DIV_T;
            end
            S_DIV_T: begin
                if (step_reg != T_STEPS) begin
                    step_next = step_reg + 3'd1;
                end else begin
                    step_next = '0;
                    if (item_reg.k == K_W1) begin
                        word_next  = {4'd0, q_calc};
                        state_next = S_EMIT;
                    end else if (item_reg.k < K_TX_N1 && q_calc == '0) begin
                        word_next  = ALL_ONES;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_DIV_N1;
                    end
                end
            end
            S_DIV_N1: begin
                if (item_reg.k < K_TX_N1) begin
                    div_num = 64'd60 << 41;
                    div_den = {4'd0, q_reg};
                    if (!launched_reg) begin
                        div_start     = 1'b1;
                        launched_next = 1'b1;
                    end else if (div_done) begin
                        launched_next = 1'b0;
                        n1_done       = 1'b1;
                    end
                end else begin
                    n1_done = 1'b1;
                end
                if (n1_done) begin
                    word_next = n1_val;
                    if (item_reg.k == K_RX_N1 || item_reg.k == K_TX_N1) begin
                        state_next = S_EMIT;
                    end else if ((item_reg.k == K_RX_INV || item_reg.k == K_TX_INV)
                                 && n1_val == '0) begin
                        word_next  = ALL_ONES;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_DIV_X;
                    end
                end
            end
            S_DIV_X: begin
                if (item_reg.k == K_TX_DEC) begin
                    word_next  = tx_dec;
                    state_next = S_EMIT;
                end else begin
                    case (item_reg.k)
                        K_RX_DEC: begin
                            div_num = {4'd0, r_reg[27:0], 32'd0} + {36'd0, q_reg};
                            div_den = {3'd0, q_reg, 1'b0};
                        end
                        default: begin
                            div_num = (64'd1 << 34) + {32'd0, n1_reg};
                            div_den = {n1_reg[30:0], 1'b0};
                        end
                    endcase
                    if (!launched_reg) begin
                        div_start     = 1'b1;
                        launched_next = 1'b1;
                    end else if (div_done) begin
                        launched_next = 1'b0;
                        word_next     = div_quot[31:0];
                        state_next    = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!res_valid_reg || m_tready) begin
                    load_res   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (pop) begin
            item_reg <= queue_item;
            b_reg    <= {3'd0, d_val} * 30'd13;
            a_reg    <= 37'(queue_item.lo) * 37'd16000000;
        end
        if (state_reg == S_DIV_N2 && div_done) begin
            n2_reg <= div_quot[8:0];
            r_reg  <= div_rem;
        end
        if (state_reg == S_DIV_F && div_done) begin
            f_reg <= div_quot[19:0];
        end
        if (state_reg == S_MUL) begin
            num_reg <= {28'd0, b_reg} * {30'd0, p_val};
            acc_reg <= '0;
        end
        if (state_reg == S_DIV_T && step_reg != T_STEPS) begin
            acc_reg <= acc_reg + mx_term;
        end
        if (state_reg == S_DIV_T && step_reg == T_STEPS) begin
            q_reg <= q_calc;
        end
        if (state_reg == S_DIV_N1 && n1_done) begin
            n1_reg <= n1_val;
            r_reg  <= div_rem;
        end
        if (load_res) begin
            res_reg <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            step_reg     <= step_next;
            if (load_res) begin
                res_valid_reg <= 1'b1;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == S_IDLE && !queue_empty))
        else $error("pop outside idle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_res |-> (!res_valid_reg || m_tready))
        else $error("result overwritten");
    a_done_launched: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> launched_reg)
        else $error("divider finished without a launch");
    a_start_once: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> !div_start)
        else $error("divider restarted");
`endif
endmodule

### rtl/pll_channel_table_word_calc.sv
// PLL channel table word calculator, top level. Magic, offset and out-of-range
// words are immediate; PLL words take two passes of the shared restoring divider,
// and channel words add a multiply, a reciprocal scaling and up to two more divider
// passes. The back end works one item at a time; a 4-entry queue takes requests.
// Reset (aresetn low, synchronous) clears the offset register to 0, the queue and result.
module pll_channel_table_word_calc #(
    parameter int QUEUE_DEPTH = pctw_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] word_index
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] table_word
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pctw_pkg::*;

    logic [XO_W-1:0] xo_reg;
    logic            push, pop, full, empty;
    item_t           push_item, pop_item;

    // Register 0 at byte address 0; pready is tied high
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {17'd0, xo_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xo_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            xo_reg <= pwdata[XO_W-1:0];
        end
    end

    // Classify the request into an immediate word or a PLL computation
    pctw_front u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .word_index     (s_tdata),
        .xo_offset_code (xo_reg),
        .queue_full     (full),
        .push           (push),
        .item           (push_item)
    );

    // Hold classified requests until the back end is free
    pctw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    // Run the arithmetic and drive the result register
    pctw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .xo_offset_code (xo_reg),
        .queue_empty    (empty),
        .queue_item     (pop_item),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .table_word     (m_tdata)
    );
endmodule

### verif/testbench.sv
// Self-checking bench for pll_channel_table_word_calc: drives word requests,
// predicts every table word and checks the result stream in order.
// Depends on pctw_pkg and the block's top level.
module testbench;
    import pctw_pkg::*;

    localparam int  NUM_PHASES = 6;
    localparam int  RAND_ITEMS = 250;      // per phase, about 1500 in all
    localparam int  DRAIN_WAIT = 400;      // longest channel word plus margin
    localparam longint LIMIT   = 4000000;

    localparam logic [2:0] ADDR_XO     = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    localparam logic [63:0] F_MASK  = 64'h7ffff;
    localparam logic [63:0] N2_MASK = 64'h1ff;
    localparam logic [63:0] M_DEN64 = 64'd1280000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] word_index
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // [31:0] table_word
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // requests waiting to go out, table words waiting to come back
    logic [7:0]  request_q[$];
    logic [31:0] word_q[$];

    logic [14:0] xo_code;       // bench copy of the offset register
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_requests;
    int          errors;
    longint      cycles;

    pll_channel_table_word_calc i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Table word prediction. All quantities fit in 64 bits: the largest
    // intermediate is 13*D*P, about 2^56.
    // ------------------------------------------------------------------

    // Signed offset folded into the VCO denominator D = 64e6 + o.
    function automatic logic [63:0] vco_denom(input logic [14:0] code);
        longint o;
        o = longint'(code);
        if (code > XO_NEG_LIMIT)
            o = o - 32768;
        return 64'(64000000 + o);
    endfunction

    // Integer part and half-up rounded 19-bit fraction of lo over the VCO step.
    function automatic void pll_divide(input logic [63:0] lo, input logic [63:0] d,
                                       output logic [63:0] n2, output logic [63:0] f);
        logic [63:0] a;
        logic [63:0] b;
        a  = lo * 64'd16000000;
        b  = 64'd13 * d;
        n2 = a / b;
        f  = (((a % b) << 20) + b) / (64'd2 * b);
    endfunction

    function automatic logic [31:0] pack_pll(input logic [63:0] n2, input logic [63:0] f);
        return 32'(((n2 & N2_MASK) << 19) | (f & F_MASK));
    endfunction

    function automatic logic [31:0] inverse_word(input logic [63:0] n1);
        if (n1 == 0)
            return ALL_ONES;
        return 32'(((64'd1 << 34) + n1) / (64'd2 * n1));
    endfunction

    function automatic logic [31:0] channel_entry(input int ch, input logic [2:0] k,
                                                  input logic [63:0] d);
        logic [63:0] lo, n2, f, p, num, den, m, g, q, n1, r;
        lo = (ch == 13) ? 64'(LO_CH_LAST) : 64'(LO_CH_BASE) + 64'(10 * ch);
        pll_divide(lo, d, n2, f);
        if (k == K_W0)
            return pack_pll(n2, f) | 32'h8000_0000;
        // f stays unmasked here, so a wrapped fraction still carries
        p   = (n2 << 19) + f;
        num = 64'd13 * d * p;
        den = M_DEN64 << 19;
        m   = num / den;
        g   = (num % den) / M_DEN64;
        if (k == K_W1)
            return pack_pll(m, g) & ~(32'd1 << 28);
        q = (m << 19) + g;
        if (k == K_RX_N1 || k == K_RX_INV || k == K_RX_DEC) begin
            if (q == 0)
                return ALL_ONES;
            n1 = (64'd60 << 41) / q;
            r  = (64'd60 << 41) % q;
            if (k == K_RX_N1)
                return 32'(n1);
            if (k == K_RX_INV)
                return inverse_word(n1);
            return 32'(((r << 32) + q) / (64'd2 * q));
        end
        n1 = (64'd2 * q) / 64'd15;
        r  = (64'd2 * q) % 64'd15;
        if (k == K_TX_N1)
            return 32'(n1);
        if (k == K_TX_INV)
            return inverse_word(n1);
        return 32'(((r << 32) + 64'd15) / 64'd30);
    endfunction

    function automatic logic [31:0] table_word_of(input logic [7:0] idx,
                                                  input logic [14:0] code);
        logic [63:0] d, lo, n2, f;
        int          rel;
        d = vco_denom(code);
        if (idx == 8'd0)
            return TBL_MAGIC;
        if (idx == IDX_OFFSET)
            return {17'd0, code};
        if (idx < IDX_FREQ_BASE) begin
            rel = int'(idx) - 2;
            return channel_entry(rel / 8, 3'(rel % 8), d);
        end
        if (idx < IDX_END) begin
            rel = int'(idx - IDX_FREQ_BASE);
            lo  = (rel == 0) ? 64'(LO_FREQ_ZERO) : 64'(LO_FREQ_BASE) + 64'(2 * (rel - 1));
            pll_divide(lo, d, n2, f);
            return pack_pll(n2, f);
        end
        return 32'd0;   // past the end of the table
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: present the next queued index, predict its word on
    // acceptance.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic free;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
        end else begin
            free = !s_tvalid;
            if (s_tvalid && s_tready) begin
                word_q.push_back(table_word_of(s_tdata, xo_code));
                free = 1'b1;
            end
            if (free) begin
                if (request_q.size() > 0 && !hold_requests &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= request_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (word_q.size() == 0) begin
                    report_mismatch("unexpected table_word", m_tdata, 32'd0);
                end else begin
                    want = word_q.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("table_word", m_tdata, want);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout with %0d words outstanding", word_q.size());
            $display("[pll_channel_table_word_calc] ERROR");
            $finish;
        end
    end

    // Register write: a setup phase, then an access phase.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_XO)
            xo_code = data[14:0];
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || s_tvalid || word_q.size() > 0)
            @(posedge aclk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            // mostly valid table words, some past the end
            if ($urandom_range(9) == 0)
                request_q.push_back(8'($urandom_range(255, 199)));
            else
                request_q.push_back(8'($urandom_range(198)));
        end
    endtask

    initial begin
        logic [14:0] settings[NUM_PHASES];
        settings = '{15'd0, 15'd32767, 15'd16384, 15'd16385, 15'd1, 15'd0};
        settings[5] = 15'($urandom_range(32767));

        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        xo_code       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = 1'b0;
        errors        = 0;
        cycles        = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset offset: magic, offset, the first and
        // the last channel in full, frequency ends and out-of-range indices.
        for (int j = 0; j < 10; j++)
            request_q.push_back(8'(j));
        for (int j = 106; j < 116; j++)
            request_q.push_back(8'(j));
        request_q.push_back(8'd198);
        request_q.push_back(8'd199);
        request_q.push_back(8'd255);
        request_q.push_back(8'd128);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // writes off register 0 must leave the offset alone
            if (ph == 1)
                reg_write(ADDR_UNUSED, 32'h0000_5555);
            reg_write(ADDR_XO, {17'($urandom()), settings[ph]});
            case (ph / 2)
                0: begin send_idle_pct = 28; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            request_q.push_back(8'd1);
            request_q.push_back(8'd2);
            if (ph == 2) begin
                // hold off until the pipeline is empty, then resume
                queue_random(RAND_ITEMS / 2);
                wait_drained();
                queue_random(RAND_ITEMS / 2);
            end else begin
                queue_random(RAND_ITEMS);
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && word_q.size() == 0)
            $display("[pll_channel_table_word_calc] OK");
        else
            $display("[pll_channel_table_word_calc] ERROR");
        $finish;
    end

endmodule
